@@ rtl/tsrr_pkg.sv @@
`default_nettype none

package tsrr_pkg;

  // Trie geometry.
  localparam int MAX_NODES  = 1024;
  localparam int ALPHABET   = 26;
  localparam int SYM_W      = 5;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int LINK_DEPTH = MAX_NODES * ALPHABET;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);

  // Symbol code for a space between words.
  localparam logic [SYM_W-1:0] SPACE_CODE = SYM_W'(26);

  // Item opcodes.
  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_SENTENCE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             kept;
    logic             sentence_end;
    logic             pool_overflow;
  } out_item_t;

  // Sentence matching mode for the current word.
  typedef enum logic [1:0] {
    MODE_MATCH = 2'd0,
    MODE_PASS  = 2'd1,
    MODE_DROP  = 2'd2
  } match_mode_t;

  // One child link entry: the end mark of the child travels with its link.
  typedef struct packed {
    logic              end_mark;
    logic [NODE_W-1:0] child;
  } link_t;

  // A write of one node's child-present row.
  typedef struct packed {
    logic                en;
    logic [NODE_W-1:0]   node;
    logic [ALPHABET-1:0] bits;
  } node_wr_t;

  function automatic logic is_letter(logic [SYM_W-1:0] s);
    return (int'(s) < ALPHABET) && (s != SPACE_CODE);
  endfunction

endpackage

`default_nettype wire

@@ rtl/trie_shortest_root_replacer_core.sv @@
// The result register loads when the accepted item completes in the lookup stage.
// A new item is taken only once the last completes, after the synchronous read of
// the current node's child-present row and child link and the cursor step.
// A result left waiting on out_ready holds the lookup stage and the input.
// Reset: rst_n is synchronous and active low; it clears the cursors, mode, node
// count, overflow flag and root row. Each new node's row is written on allocation.
`default_nettype none

module trie_shortest_root_replacer_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  tsrr_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output tsrr_pkg::out_item_t   out_data
);
  import tsrr_pkg::*;

  // Lookup stage and architectural state.
  logic              busy_r;
  in_item_t          cap_r;
  logic [NODE_W-1:0] ins_cur_r,  ins_cur_nxt;
  logic [LINK_AW-1:0] ins_par_r, ins_par_nxt;
  logic              ins_skip_r, ins_skip_nxt;
  logic [NODE_W-1:0] match_cur_r, match_cur_nxt;
  match_mode_t       mode_r,     mode_nxt;
  logic [CNT_W-1:0]  nodes_used_r, nodes_used_nxt;
  logic              ovf_r,      ovf_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic              done;
  in_item_t          item;
  logic [NODE_W-1:0] cur_sel;
  logic [LINK_AW-1:0] link_rd_addr;

  // Link memory.
  link_t             link_mem [LINK_DEPTH];
  link_t             link_q;
  logic              link_we;
  logic [LINK_AW-1:0] link_wa;
  link_t             link_wd;

  // Node rows.
  node_wr_t            wr_now;
  node_wr_t            wr_late;
  logic [ALPHABET-1:0] present;

  // Handshake: a new transaction enters once the lookup stage is free.
  assign in_ready  = !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign done      = busy_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Read addresses come from the held item while it is in the lookup stage.
  assign item    = busy_r ? cap_r : in_data;
  assign cur_sel = (item.op == OP_SENTENCE) ? match_cur_r : ins_cur_r;
  assign link_rd_addr = LINK_AW'(cur_sel) * LINK_AW'(ALPHABET)
                      + LINK_AW'(is_letter(item.symbol) ? item.symbol : '0);

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[link_rd_addr];
  end

  tsrr_node_store u_nodes (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_node (cur_sel),
    .wr_now  (wr_now),
    .wr_late (wr_late),
    .rd_bits (present)
  );

  // Step logic for the item in the lookup stage.
  always_comb begin
    logic              letter;
    logic              hit;
    logic [NODE_W-1:0] fresh;
    logic              kept;

    ins_cur_nxt    = ins_cur_r;
    ins_par_nxt    = ins_par_r;
    ins_skip_nxt   = ins_skip_r;
    match_cur_nxt  = match_cur_r;
    mode_nxt       = mode_r;
    nodes_used_nxt = nodes_used_r;
    ovf_nxt        = ovf_r;
    link_we        = 1'b0;
    link_wa        = link_rd_addr;
    link_wd        = link_q;
    wr_now         = '0;
    wr_late        = '0;
    kept           = 1'b0;

    letter = is_letter(cap_r.symbol);
    hit    = letter ? present[cap_r.symbol] : 1'b0;
    fresh  = nodes_used_r[NODE_W-1:0];

    if (cap_r.op == OP_INSERT) begin
      // Dictionary insert walk.
      if (!ins_skip_r && letter) begin
        if (hit) begin
          ins_cur_nxt = link_q.child;
          ins_par_nxt = link_rd_addr;
        end else if (nodes_used_r < CNT_W'(MAX_NODES)) begin
          link_we        = 1'b1;
          link_wd        = '{end_mark: 1'b0, child: fresh};
          wr_now         = '{en: 1'b1, node: fresh, bits: '0};
          wr_late        = '{en: 1'b1, node: ins_cur_r,
                             bits: present | (ALPHABET'(1) << cap_r.symbol)};
          nodes_used_nxt = nodes_used_r + CNT_W'(1);
          ins_cur_nxt    = fresh;
          ins_par_nxt    = link_rd_addr;
        end else begin
          ovf_nxt      = 1'b1;
          ins_skip_nxt = 1'b1;
        end
      end
      // End of a root word: mark the node through its parent's link entry.
      if (cap_r.last) begin
        if (!ins_skip_nxt && (ins_cur_nxt != '0)) begin
          link_we = 1'b1;
          link_wa = ins_par_nxt;
          link_wd = '{end_mark: 1'b1, child: ins_cur_nxt};
        end
        ins_cur_nxt  = '0;
        ins_skip_nxt = 1'b0;
      end
    end else begin
      // Sentence walk.
      if (cap_r.symbol == SPACE_CODE) begin
        kept          = 1'b1;
        match_cur_nxt = '0;
        mode_nxt      = MODE_MATCH;
      end else if (letter) begin
        case (mode_r)
          MODE_MATCH: begin
            kept = 1'b1;
            if (hit) begin
              match_cur_nxt = link_q.child;
              if (link_q.end_mark) begin
                mode_nxt = MODE_DROP;
              end
            end else begin
              mode_nxt = MODE_PASS;
            end
          end
          MODE_PASS: begin
            kept = 1'b1;
          end
          default: begin
            kept = 1'b0;
          end
        endcase
      end
      if (cap_r.last) begin
        match_cur_nxt = '0;
        mode_nxt      = MODE_MATCH;
      end
    end

    if (!done) begin
      link_we = 1'b0;
      wr_now  = '0;
      wr_late = '0;
    end

    out_data_nxt = '{out_symbol:    cap_r.symbol,
                     kept:          kept,
                     sentence_end:  (cap_r.op == OP_SENTENCE) && cap_r.last,
                     pool_overflow: ovf_nxt};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      ins_cur_r    <= '0;
      ins_par_r    <= '0;
      ins_skip_r   <= 1'b0;
      match_cur_r  <= '0;
      mode_r       <= MODE_MATCH;
      nodes_used_r <= CNT_W'(1);
      ovf_r        <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        out_valid_r  <= 1'b1;
        ins_cur_r    <= ins_cur_nxt;
        ins_par_r    <= ins_par_nxt;
        ins_skip_r   <= ins_skip_nxt;
        match_cur_r  <= match_cur_nxt;
        mode_r       <= mode_nxt;
        nodes_used_r <= nodes_used_nxt;
        ovf_r        <= ovf_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cap_r <= in_data;
    end
    if (done) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Two completions never fall in adjacent cycles; the node store's
  // deferred write relies on a free write port in the following cycle.
  a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("back-to-back completions");

  // Both cursors always point at allocated nodes.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(ins_cur_r) < nodes_used_r) && (CNT_W'(match_cur_r) < nodes_used_r))
    else $error("cursor beyond allocated nodes");

  // The node count stays within the pool.
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_used_r != '0) && (nodes_used_r <= CNT_W'(MAX_NODES)))
    else $error("node count out of range");

  // The overflow flag is sticky.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

endmodule

`default_nettype wire

@@ rtl/tsrr_node_store.sv @@
`default_nettype none

module tsrr_node_store (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [tsrr_pkg::NODE_W-1:0]         rd_node,
  input  wire  tsrr_pkg::node_wr_t            wr_now,
  input  wire  tsrr_pkg::node_wr_t            wr_late,
  output logic [tsrr_pkg::ALPHABET-1:0]       rd_bits
);
  import tsrr_pkg::*;

  logic [ALPHABET-1:0] node_mem [MAX_NODES];
  logic [ALPHABET-1:0] mem_q;

  logic                root_r;
  logic [ALPHABET-1:0] root_bits_r;
  logic                pend_v_r;
  logic [NODE_W-1:0]   pend_node_r;
  logic [ALPHABET-1:0] pend_bits_r;
  logic                fwd_hit_r;
  logic [ALPHABET-1:0] fwd_bits_r;

  logic                mem_we;
  logic [NODE_W-1:0]   mem_wa;
  logic [ALPHABET-1:0] mem_wd;

  // The root row lives in flops so that it is empty right after reset.
  // A deferred write to another node is registered and written in the following
  // cycle; a read issued in that cycle takes the held data instead.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_now.node;
    mem_wd = wr_now.bits;
    if (pend_v_r) begin
      mem_we = 1'b1;
      mem_wa = pend_node_r;
      mem_wd = pend_bits_r;
    end else if (wr_now.en && (wr_now.node != '0)) begin
      mem_we = 1'b1;
    end
  end

  // Node memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_wa] <= mem_wd;
    end
    mem_q <= node_mem[rd_node];
  end

  // Control state and the root row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_bits_r <= '0;
      pend_v_r    <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      fwd_hit_r <= pend_v_r && (pend_node_r == rd_node);
      pend_v_r  <= wr_late.en && (wr_late.node != '0);
      if (wr_late.en && (wr_late.node == '0)) begin
        root_bits_r <= wr_late.bits;
      end else if (wr_now.en && (wr_now.node == '0)) begin
        root_bits_r <= wr_now.bits;
      end
    end
  end

  // Payload registers for the read side and the deferred write.
  always_ff @(posedge clk) begin
    root_r      <= (rd_node == '0);
    fwd_bits_r  <= pend_bits_r;
    pend_node_r <= wr_late.node;
    pend_bits_r <= wr_late.bits;
  end

  // Resolve the row for the address read in the previous cycle.
  always_comb begin
    if (root_r) begin
      rd_bits = root_bits_r;
    end else if (fwd_hit_r) begin
      rd_bits = fwd_bits_r;
    end else begin
      rd_bits = mem_q;
    end
  end

endmodule

`default_nettype wire

@@ tb/trie_replace_checker.sv @@
module trie_replace_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  tsrr_pkg::in_item_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  tsrr_pkg::out_item_t  out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);
  import tsrr_pkg::*;

  // Shadow copy of the trie and of both walks.
  logic [NODE_W-1:0]   link_tab [MAX_NODES][ALPHABET];
  logic [ALPHABET-1:0] kid_bits [MAX_NODES];
  logic                root_end [MAX_NODES];
  logic [CNT_W-1:0]    nodes_taken;
  logic [NODE_W-1:0]   ins_at;
  logic [NODE_W-1:0]   walk_at;
  match_mode_t         walk_mode;
  logic                pool_full_seen;
  logic                ins_abandon;

  // Results predicted for accepted transactions, oldest first.
  out_item_t predicted_symbols[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic logic letter_code(logic [SYM_W-1:0] s);
    return (s < ALPHABET) && (s != SPACE_CODE);
  endfunction

  function automatic void clear_trie();
    for (int n = 0; n < MAX_NODES; n++) begin
      kid_bits[n] = '0;
      root_end[n] = 1'b0;
    end
    nodes_taken    = CNT_W'(1);
    ins_at         = '0;
    walk_at        = '0;
    walk_mode      = MODE_MATCH;
    pool_full_seen = 1'b0;
    ins_abandon    = 1'b0;
  endfunction

  // Apply one transaction to the shadow trie and return the result it yields.
  function automatic out_item_t step_trie(in_item_t it);
    out_item_t         r;
    logic [NODE_W-1:0] cur;
    logic              keep;
    r    = '0;
    keep = 1'b0;
    if (it.op == OP_INSERT) begin
      cur = ins_at;
      if (!ins_abandon && letter_code(it.symbol)) begin
        if (kid_bits[cur][it.symbol]) begin
          cur = link_tab[cur][it.symbol];
        end else if (nodes_taken < MAX_NODES) begin
          kid_bits[nodes_taken] = '0;
          root_end[nodes_taken] = 1'b0;
          link_tab[cur][it.symbol] = nodes_taken[NODE_W-1:0];
          kid_bits[cur][it.symbol] = 1'b1;
          cur = nodes_taken[NODE_W-1:0];
          nodes_taken = nodes_taken + 1'b1;
        end else begin
          // Pool exhausted: the rest of this word is abandoned.
          pool_full_seen = 1'b1;
          ins_abandon    = 1'b1;
        end
      end
      if (it.last) begin
        // The root itself never becomes a root end.
        if (!ins_abandon && cur != '0) root_end[cur] = 1'b1;
        cur         = '0;
        ins_abandon = 1'b0;
      end
      ins_at = cur;
    end else begin
      cur = walk_at;
      if (it.symbol == SPACE_CODE) begin
        keep      = 1'b1;
        cur       = '0;
        walk_mode = MODE_MATCH;
      end else if (letter_code(it.symbol)) begin
        case (walk_mode)
          MODE_MATCH: begin
            keep = 1'b1;
            if (kid_bits[cur][it.symbol]) begin
              cur = link_tab[cur][it.symbol];
              if (root_end[cur]) walk_mode = MODE_DROP;
            end else begin
              walk_mode = MODE_PASS;
            end
          end
          MODE_PASS: keep = 1'b1;
          default:   keep = 1'b0;
        endcase
      end
      if (it.last) begin
        cur       = '0;
        walk_mode = MODE_MATCH;
      end
      walk_at = cur;
      r.sentence_end = it.last;
    end
    r.out_symbol    = it.symbol;
    r.kept          = keep;
    r.pool_overflow = pool_full_seen;
    return r;
  endfunction

  // Predict on every accepted input and compare every accepted result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_trie();
      predicted_symbols.delete();
    end else begin
      if (in_valid && in_ready)
        predicted_symbols.insert(predicted_symbols.size(), step_trie(in_data));
      if (out_valid && out_ready) begin
        if (predicted_symbols.size() == 0) begin
          $display("%0t: result with none expected, got sym=%0d kept=%0b end=%0b ovf=%0b",
                   $time, out_data.out_symbol, out_data.kept, out_data.sentence_end,
                   out_data.pool_overflow);
          fail_count = fail_count + 1;
        end else begin
          want = predicted_symbols.pop_front();
          checked = checked + 1;
          if (out_data.out_symbol !== want.out_symbol || out_data.kept !== want.kept ||
              out_data.sentence_end !== want.sentence_end ||
              out_data.pool_overflow !== want.pool_overflow) begin
            $display("%0t: mismatch, expected sym=%0d kept=%0b end=%0b ovf=%0b, %s",
                     $time, want.out_symbol, want.kept, want.sentence_end,
                     want.pool_overflow,
                     $sformatf("got sym=%0d kept=%0b end=%0b ovf=%0b",
                               out_data.out_symbol, out_data.kept,
                               out_data.sentence_end, out_data.pool_overflow));
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = predicted_symbols.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import tsrr_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int pending;
  int checked;
  int quiet_cycles = 0;
  int items_sent   = 0;
  int dict_items   = 0;
  int text_items   = 0;
  int burst_left   = 0;
  bit hold_req     = 1'b0;
  bit overflow_hit = 1'b0;

  always #1 clk = ~clk;

  trie_shortest_root_replacer_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  trie_replace_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready && out_data.pool_overflow) overflow_hit <= 1'b1;
  end

  // Result side: stretches of steady, light, heavy or alternating stalls,
  // and once a long hold-off so the block backs up into its input.
  initial begin : receiver
    int style;
    int len;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      len   = $urandom_range(10, 80);
      repeat (len) begin
        @(posedge clk);
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
      if (hold_req && !hold_done) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
    end
  end

  // Offer one transaction and wait for it to be taken; the sender then either
  // keeps going in its burst or drops valid for a random gap.
  task automatic send_item(logic op, logic [SYM_W-1:0] sym, logic last);
    in_item_t it;
    bit       rdy;
    int       gap;
    it.op     = op;
    it.symbol = sym;
    it.last   = last;
    in_data  <= it;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    items_sent = items_sent + 1;
    if (op == OP_INSERT) dict_items = dict_items + 1;
    else text_items = text_items + 1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(1, 9);
      in_valid  <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left = burst_left - 1;
    end
  endtask

  function automatic logic [SYM_W-1:0] pick_letter(int span);
    return SYM_W'($urandom_range(0, span - 1));
  endfunction

  // A dictionary word; length zero gives an empty word ended by a non-letter.
  task automatic put_root(int len, int span);
    logic [SYM_W-1:0] sym;
    if (len == 0) begin
      send_item(OP_INSERT, SYM_W'($urandom_range(26, 31)), 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        sym = ($urandom_range(0, 19) == 0) ? SYM_W'($urandom_range(26, 31))
                                           : pick_letter(span);
        send_item(OP_INSERT, sym, i == len - 1);
      end
    end
  endtask

  // A sentence of several words split by spaces, flagged on its final symbol.
  task automatic put_sentence(int words, int span);
    logic [SYM_W-1:0] sym;
    int               len;
    bit               trail;
    trail = ($urandom_range(0, 7) == 0);
    for (int w = 0; w < words; w++) begin
      len = $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
        sym = ($urandom_range(0, 24) == 0) ? SYM_W'($urandom_range(27, 31))
                                           : pick_letter(span);
        send_item(OP_SENTENCE, sym, !trail && w == words - 1 && i == len - 1);
      end
      if (w != words - 1) begin
        send_item(OP_SENTENCE, SPACE_CODE, 1'b0);
        if ($urandom_range(0, 9) == 0) send_item(OP_SENTENCE, SPACE_CODE, 1'b0);
      end
    end
    if (trail) send_item(OP_SENTENCE, SPACE_CODE, 1'b1);
  endtask

  // Mostly well-formed roots and sentences over narrow alphabets, some noise.
  task automatic random_mix(int count);
    int stop;
    int pick;
    int span;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 19);
      span = ($urandom_range(0, 4) == 0) ? ALPHABET : $urandom_range(2, 6);
      if (pick < 5)
        put_root($urandom_range(0, 5), span);
      else if (pick < 17)
        put_sentence($urandom_range(1, 6), span);
      else
        send_item(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed roots: "ab", "z", an empty word, "c" ended by a non-letter,
    // and "d" after a space that the dictionary ignores.
    send_item(OP_INSERT, 5'd0, 1'b0);
    send_item(OP_INSERT, 5'd1, 1'b1);
    send_item(OP_INSERT, 5'd25, 1'b1);
    send_item(OP_INSERT, 5'd27, 1'b1);
    send_item(OP_INSERT, 5'd2, 1'b0);
    send_item(OP_INSERT, 5'd31, 1'b1);
    send_item(OP_INSERT, SPACE_CODE, 1'b0);
    send_item(OP_INSERT, 5'd3, 1'b1);

    // Directed sentence: a replaced word with a dropped tail, a one-letter
    // root, a word with no match, a junk symbol, and a junk sentence end.
    send_item(OP_SENTENCE, 5'd0, 1'b0);
    send_item(OP_SENTENCE, 5'd1, 1'b0);
    send_item(OP_SENTENCE, 5'd0, 1'b0);
    send_item(OP_SENTENCE, SPACE_CODE, 1'b0);
    send_item(OP_SENTENCE, 5'd25, 1'b0);
    send_item(OP_SENTENCE, 5'd25, 1'b0);
    send_item(OP_SENTENCE, SPACE_CODE, 1'b0);
    send_item(OP_SENTENCE, 5'd16, 1'b0);
    send_item(OP_SENTENCE, 5'd0, 1'b0);
    send_item(OP_SENTENCE, 5'd29, 1'b0);
    send_item(OP_SENTENCE, SPACE_CODE, 1'b0);
    send_item(OP_SENTENCE, 5'd31, 1'b1);
    send_item(OP_SENTENCE, 5'd0, 1'b1);
    send_item(OP_SENTENCE, 5'd3, 1'b1);

    // Random traffic, with the long result hold-off requested early on.
    hold_req = 1'b1;
    random_mix(300);

    // Long random roots over the full alphabet, with sentences in between.
    for (int k = 0; k < 10; k++) begin
      put_root(18, ALPHABET);
      if (k % 5 == 4) put_sentence(3, ALPHABET);
    end

    // More random traffic over the grown trie.
    random_mix(80);

    // Drain.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d dictionary and %0d sentence transactions, %0d results checked.",
             dict_items, text_items, checked);
    $display("Node pool overflow %s during the run.",
             overflow_hit ? "was reached" : "was not reached");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tsrr_pkg.sv
rtl/tsrr_node_store.sv
rtl/trie_shortest_root_replacer_core.sv
tb/trie_replace_checker.sv
tb/tb_top.sv
